>>> src/fpba_pkg.sv
// fpba_pkg: shared types and codes for the fit-policy block allocator
// words on the request and result channels, cell probe and write command
// no dependencies
package fpba_pkg;

  localparam int AMT_W     = 16;  // amount and remaining fields
  localparam int BIDX_W    = 4;   // block_index and chosen_block fields
  localparam int CAP_W_MAX = 32;  // widest capacity a cell may hold
  localparam int IDX_W_MAX = 8;   // widest cell index
  localparam int BCNT_W    = 5;   // block_count register
  localparam int CFG_W     = 5;   // widest configuration register
  localparam int CFG_IDX_W = 1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_GRANT = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic              kind;
    logic [BIDX_W-1:0] block_index;
    logic [AMT_W-1:0]  amount;
  } req_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [BIDX_W-1:0] chosen_block;
    logic [AMT_W-1:0]  remaining;
  } rsp_word_t;

  // search record walking down the cell row, one cell per cycle
  // candidate a: first/best/worst fit, or next fit at or after the pointer
  // candidate b: next fit below the pointer (wrap-around)
  typedef struct packed {
    logic                 valid;
    policy_t              policy;
    logic [AMT_W-1:0]     size;
    logic [IDX_W_MAX-1:0] ptr;
    logic [IDX_W_MAX:0]   lim;
    logic                 hit_a;
    logic [IDX_W_MAX-1:0] idx_a;
    logic [CAP_W_MAX-1:0] cap_a;
    logic                 hit_b;
    logic [IDX_W_MAX-1:0] idx_b;
    logic [CAP_W_MAX-1:0] cap_b;
  } probe_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_W_MAX-1:0] index;
    logic [CAP_W_MAX-1:0] value;
  } wr_cmd_t;

endpackage

>>> src/fpba_req_if.sv
// fpba_req_if: request channel of the fit-policy block allocator
// valid/ready handshake carrying one req_word_t; depends on fpba_pkg
interface fpba_req_if
  import fpba_pkg::*;
();
  logic      valid;
  logic      ready;
  req_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/fpba_rsp_if.sv
// fpba_rsp_if: result channel of the fit-policy block allocator
// valid/ready handshake carrying one rsp_word_t; depends on fpba_pkg
interface fpba_rsp_if
  import fpba_pkg::*;
();
  logic      valid;
  logic      ready;
  rsp_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/fpba_cell.sv
// fpba_cell: one block of the allocator; holds its remaining capacity,
// updates the passing search record and hands it on to the next cell
// depends on fpba_pkg
module fpba_cell
  import fpba_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int SIZE_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  probe_t  pin,
  output probe_t  pout,
  input  wr_cmd_t wr
);

  logic [SIZE_BITS-1:0] cap;
  logic [CAP_W_MAX-1:0] cap_ext;
  logic [IDX_W_MAX-1:0] my_idx;
  logic                 in_use;
  logic                 fits;
  probe_t               pnext;

  assign cap_ext = CAP_W_MAX'(cap);
  assign my_idx  = IDX_W_MAX'(IDX);
  assign in_use  = (IDX_W_MAX + 1)'(IDX) < pin.lim;
  assign fits    = in_use && (cap_ext >= CAP_W_MAX'(pin.size));

  always_comb begin
    pnext = pin;
    unique case (pin.policy)
      POL_FIRST: begin
        if (fits && !pin.hit_a) begin
          pnext.hit_a = 1'b1;
          pnext.idx_a = my_idx;
          pnext.cap_a = cap_ext;
        end
      end
      POL_BEST: begin
        // strict compare keeps the lowest index on ties
        if (fits && (!pin.hit_a || cap_ext < pin.cap_a)) begin
          pnext.hit_a = 1'b1;
          pnext.idx_a = my_idx;
          pnext.cap_a = cap_ext;
        end
      end
      POL_WORST: begin
        if (fits && (!pin.hit_a || cap_ext > pin.cap_a)) begin
          pnext.hit_a = 1'b1;
          pnext.idx_a = my_idx;
          pnext.cap_a = cap_ext;
        end
      end
      POL_NEXT: begin
        if (fits && my_idx >= pin.ptr && !pin.hit_a) begin
          pnext.hit_a = 1'b1;
          pnext.idx_a = my_idx;
          pnext.cap_a = cap_ext;
        end
        if (fits && my_idx < pin.ptr && !pin.hit_b) begin
          pnext.hit_b = 1'b1;
          pnext.idx_b = my_idx;
          pnext.cap_b = cap_ext;
        end
      end
      default: begin
        pnext = pin;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout.valid <= 1'b0;
    end else begin
      pout <= pnext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= '0;
    end else if (wr.en && wr.index == my_idx) begin
      cap <= wr.value[SIZE_BITS-1:0];
    end
  end

endmodule

>>> src/fit_policy_block_allocator.sv
// fit_policy_block_allocator: top level; control, configuration registers
// and the row of fpba_cell blocks; depends on fpba_pkg, fpba_req_if,
// fpba_rsp_if and fpba_cell
//
// Keeps the remaining capacity of up to BLOCKS memory blocks, one per cell
// in a row. A load word writes one block (saturated to SIZE_BITS) and sends
// the next-fit pointer back to block 0; an index outside the row writes no
// block. A request word launches a search record into cell 0 which moves
// one cell per cycle, each cell applying the configured policy (first, best,
// worst or next fit); the record leaving the last cell is captured and then
// the result is registered. The chosen block
// is written back as the result is registered. One word is in flight at a
// time; the next one is accepted in the cycle after a result is registered,
// even while that result still waits to be taken.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int BLOCKS    = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  fpba_req_if.sink             req,
  fpba_rsp_if.source           rsp
);

  localparam int IDX_W = $clog2(BLOCKS);
  localparam logic [IDX_W_MAX:0] BLOCKS_LIM = (IDX_W_MAX + 1)'(BLOCKS);
  localparam logic [CAP_W_MAX-1:0] CAP_MAX_EXT =
    CAP_W_MAX'((64'd1 << SIZE_BITS) - 64'd1);

  ctl_state_t state, state_next;

  policy_t              policy;
  logic [BCNT_W-1:0]    block_count;
  logic [IDX_W-1:0]     next_pointer;

  logic                 it_kind;
  logic [BIDX_W-1:0]    it_index;
  logic [AMT_W-1:0]     it_amount;

  logic                 res_hit;
  logic [IDX_W_MAX-1:0] res_idx;
  logic [CAP_W_MAX-1:0] res_cap;

  logic                 out_valid;
  rsp_word_t            out_word;

  logic                 accept;
  logic                 done_fire;
  logic [IDX_W_MAX:0]   lim;
  logic [IDX_W-1:0]     ptr_norm;
  probe_t               launch;
  probe_t               chain [BLOCKS+1];
  probe_t               cend;
  wr_cmd_t              wr;
  rsp_word_t            word;
  logic [CAP_W_MAX-1:0] cap_sat;
  logic [CAP_W_MAX-1:0] diff;
  logic                 in_range;

  assign accept    = req.valid && req.ready;
  assign done_fire = (state == S_DONE) && (!out_valid || rsp.ready);

  assign lim = ((IDX_W_MAX + 1)'(block_count) > BLOCKS_LIM) ? BLOCKS_LIM
             : (IDX_W_MAX + 1)'(block_count);
  assign ptr_norm = ((IDX_W_MAX + 1)'(next_pointer) < lim) ? next_pointer : '0;

  // launch record into cell 0
  always_comb begin
    launch        = '0;
    launch.valid  = accept && (req.data.kind == KIND_REQ);
    launch.policy = policy;
    launch.size   = req.data.amount;
    launch.ptr    = IDX_W_MAX'(ptr_norm);
    launch.lim    = lim;
  end

  assign chain[0] = launch;

  for (genvar g = 0; g < BLOCKS; g++) begin : g_cell
    fpba_cell #(
      .IDX       (g),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .pin  (chain[g]),
      .pout (chain[g+1]),
      .wr   (wr)
    );
  end

  assign cend = chain[BLOCKS];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.data.kind == KIND_LOAD) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (cend.valid) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs: result word and write-back command
  always_comb begin
    cap_sat  = (CAP_W_MAX'(it_amount) > CAP_MAX_EXT) ? CAP_MAX_EXT
             : CAP_W_MAX'(it_amount);
    in_range = (IDX_W_MAX + 1)'(it_index) < BLOCKS_LIM;
    diff     = res_cap - CAP_W_MAX'(it_amount);
    wr       = '0;
    word     = '0;
    req.ready = (state == S_IDLE);
    if (it_kind == KIND_LOAD) begin
      word.status       = ST_LOAD;
      word.chosen_block = it_index;
      word.remaining    = in_range ? cap_sat[AMT_W-1:0] : '0;
      wr.en             = done_fire && in_range;
      wr.index          = IDX_W_MAX'(it_index);
      wr.value          = cap_sat;
    end else if (res_hit) begin
      word.status       = ST_GRANT;
      word.chosen_block = res_idx[BIDX_W-1:0];
      word.remaining    = diff[AMT_W-1:0];
      wr.en             = done_fire;
      wr.index          = res_idx;
      wr.value          = diff;
    end else begin
      word.status       = ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item fields
  always_ff @(posedge clk) begin
    if (accept) begin
      it_kind   <= req.data.kind;
      it_index  <= req.data.block_index;
      it_amount <= req.data.amount;
    end
  end

  // capture the record leaving the last cell
  always_ff @(posedge clk) begin
    if (state == S_SCAN && cend.valid) begin
      if (cend.policy == POL_NEXT && !cend.hit_a) begin
        res_hit <= cend.hit_b;
        res_idx <= cend.idx_b;
        res_cap <= cend.cap_b;
      end else begin
        res_hit <= cend.hit_a;
        res_idx <= cend.idx_a;
        res_cap <= cend.cap_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_pointer <= '0;
    end else if (done_fire) begin
      if (it_kind == KIND_LOAD) begin
        next_pointer <= '0;
      end else if (res_hit && policy == POL_NEXT) begin
        next_pointer <= res_idx[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POL_FIRST;
      block_count <= BCNT_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY:      policy      <= policy_t'(cfg_wdata[1:0]);
        REG_BLOCK_COUNT: block_count <= cfg_wdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (out_valid && rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_word <= word;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

endmodule

>>> test/testbench.sv
// testbench for fit_policy_block_allocator: directed table, then random phases
// checks every result word against its expected word from the table or an in-bench allocation predictor
// depends on fpba_pkg, fpba_req_if, fpba_rsp_if and the allocator rtl
module testbench
  import fpba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK       = 16;
  localparam int QUIET_MAX  = 2000;
  localparam int PHASES     = 27;
  localparam int PHASE_LEN  = 50;
  localparam int TAIL_WAIT  = 40;

  typedef struct {
    bit          cfg_row;
    policy_t     pol;
    logic [4:0]  cnt;
    req_word_t   w;
    bit          typed;
    rsp_word_t   want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  fpba_req_if req_ch ();
  fpba_rsp_if rsp_ch ();

  fit_policy_block_allocator #(
    .BLOCKS    (NBLK),
    .SIZE_BITS (16)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // predictor state
  logic [AMT_W-1:0] block_cap [NBLK];
  logic [3:0]       rover;
  policy_t          cur_policy;
  logic [4:0]       cur_count;

  rsp_word_t pending_results [$];
  int        mismatches;
  int        quiet;
  bit        steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic rsp_word_t predict_result(input req_word_t w);
    rsp_word_t r;
    int        n;
    int        pick;
    int        p;
    r = '0;
    if (w.kind == KIND_LOAD) begin
      block_cap[w.block_index] = w.amount;
      rover = '0;
      r.status       = ST_LOAD;
      r.chosen_block = w.block_index;
      r.remaining    = w.amount;
      return r;
    end
    n    = (cur_count > NBLK) ? NBLK : int'(cur_count);
    pick = -1;
    if (n > 0 && cur_policy == POL_NEXT) begin
      // circular walk from the rover, wrapping at the blocks in use
      p = (int'(rover) < n) ? int'(rover) : 0;
      for (int j = 0; j < n; j++) begin
        if (pick < 0 && block_cap[p] >= w.amount) pick = p;
        p = (p + 1 == n) ? 0 : p + 1;
      end
      if (pick >= 0) rover = pick[3:0];
    end else begin
      for (int j = 0; j < n; j++) begin
        if (block_cap[j] >= w.amount &&
            (pick < 0 ||
             (cur_policy == POL_BEST && block_cap[j] < block_cap[pick]) ||
             (cur_policy == POL_WORST && block_cap[j] > block_cap[pick])))
          pick = j;
      end
    end
    if (pick < 0) begin
      r.status = ST_MISS;
    end else begin
      block_cap[pick] = block_cap[pick] - w.amount;
      r.status       = ST_GRANT;
      r.chosen_block = pick[3:0];
      r.remaining    = block_cap[pick];
    end
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input policy_t pol, input logic [4:0] cnt);
    plan_row_t row;
    row = '{default: '0, pol: pol};
    row.cfg_row = 1'b1;
    row.cnt     = cnt;
    return row;
  endfunction

  function automatic plan_row_t word_row(input logic kind, input logic [3:0] idx,
                                         input logic [15:0] amt, input bit typed,
                                         input logic [1:0] st, input logic [3:0] blk,
                                         input logic [15:0] rem);
    plan_row_t row;
    row = '{default: '0, pol: POL_FIRST};
    row.w.kind             = kind;
    row.w.block_index      = idx;
    row.w.amount           = amt;
    row.typed              = typed;
    row.want.status        = st;
    row.want.chosen_block  = blk;
    row.want.remaining     = rem;
    return row;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: bad %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // entered and left at a falling edge
  task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t want);
    rsp_word_t predicted;
    while (!steady && $urandom_range(0, 99) < 30) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_result(w);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // waits for the allocator to drain, then writes both registers
  task automatic reconfigure(input policy_t pol, input logic [4:0] cnt);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_POLICY;
    cfg_wdata <= {3'b000, pol};
    @(negedge clk);
    cfg_index <= REG_BLOCK_COUNT;
    cfg_wdata <= cnt;
    @(negedge clk);
    cfg_we     <= 1'b0;
    cur_policy = pol;
    cur_count  = cnt;
  endtask

  // result side: random back-pressure, none in steady phases
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
    end
  end

  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word", 32'(rsp_ch.data), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.data.status != want.status)
          flag_mismatch("status", 32'(rsp_ch.data.status), 32'(want.status));
        if (rsp_ch.data.chosen_block != want.chosen_block)
          flag_mismatch("chosen_block", 32'(rsp_ch.data.chosen_block),
                        32'(want.chosen_block));
        if (rsp_ch.data.remaining != want.remaining)
          flag_mismatch("remaining", 32'(rsp_ch.data.remaining),
                        32'(want.remaining));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("fit_policy_block_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan [$];
    req_word_t   w;
    policy_t     pol;
    logic [4:0]  cnt;
    int          pick;
    mismatches = 0;
    quiet      = 0;
    steady     = 1'b0;
    for (int i = 0; i < NBLK; i++) block_cap[i] = '0;
    rover      = '0;
    cur_policy = POL_FIRST;
    cur_count  = 5'd16;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_POLICY;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;

    // after reset: zero-size request fits an empty block, anything else misses
    plan.push_back(word_row(KIND_REQ, 4'd5, 16'd0, 1, ST_GRANT, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_REQ, 4'd10, 16'd1, 1, ST_MISS, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_LOAD, 4'd15, 16'hFFFF, 1, ST_LOAD, 4'd15, 16'hFFFF));
    plan.push_back(word_row(KIND_LOAD, 4'd0, 16'd0, 1, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_LOAD, 4'd3, 16'd100, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_LOAD, 4'd7, 16'd50, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_LOAD, 4'd9, 16'd200, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd60, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_REQ, 4'd15, 16'hFFFF, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(cfg_row(POL_BEST, 5'd16));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd30, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd0, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(cfg_row(POL_WORST, 5'd16));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd10, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd10, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(cfg_row(POL_NEXT, 5'd16));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd45, 0, ST_LOAD, 4'd0, 16'd0));
    // failed next-fit search leaves the rover alone
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'hFFFF, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd5, 0, ST_LOAD, 4'd0, 16'd0));
    // rover now beyond the blocks in use: search restarts at block 0
    plan.push_back(cfg_row(POL_NEXT, 5'd4));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd1, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(cfg_row(POL_NEXT, 5'd16));
    plan.push_back(word_row(KIND_LOAD, 4'd12, 16'hA5A5, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd1, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(cfg_row(POL_FIRST, 5'd0));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd0, 1, ST_MISS, 4'd0, 16'd0));
    plan.push_back(cfg_row(POL_BEST, 5'd31));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd7, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(cfg_row(POL_WORST, 5'd1));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd3, 0, ST_LOAD, 4'd0, 16'd0));
    plan.push_back(cfg_row(POL_NEXT, 5'd17));
    plan.push_back(word_row(KIND_REQ, 4'd0, 16'd2, 0, ST_LOAD, 4'd0, 16'd0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg_row)
        reconfigure(plan[i].pol, plan[i].cnt);
      else
        send_word(plan[i].w, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // early phases sweep every policy against the count extremes
      if (ph < 8) begin
        pol = policy_t'(ph % 4);
        case (ph)
          0: cnt = 5'd16;
          1: cnt = 5'd1;
          2: cnt = 5'd31;
          3: cnt = 5'd2;
          4: cnt = 5'd0;
          5: cnt = 5'd17;
          default: cnt = 5'd16;
        endcase
      end else begin
        pol  = policy_t'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        case (pick)
          0: cnt = 5'd1;
          1: cnt = 5'($urandom_range(17, 31));
          2, 3: cnt = 5'd16;
          4: cnt = (ph % 5 == 0) ? 5'd0 : 5'd16;
          default: cnt = 5'($urandom_range(2, 16));
        endcase
      end
      reconfigure(pol, cnt);
      steady = (ph == 12 || ph == 13);
      for (int k = 0; k < PHASE_LEN; k++) begin
        w.kind        = ($urandom_range(0, 99) < 30) ? KIND_LOAD : KIND_REQ;
        w.block_index = 4'($urandom_range(0, 15));
        if (w.kind == KIND_LOAD) begin
          // mostly refill blocks that are searched
          if (cnt != 0 && $urandom_range(0, 9) < 7)
            w.block_index = 4'($urandom_range(0, (cnt > NBLK ? NBLK : cnt) - 1));
          pick = $urandom_range(0, 9);
          case (pick)
            0: w.amount = 16'd0;
            1: w.amount = 16'hFFFF;
            2, 3: w.amount = 16'($urandom_range(0, 16'hFFFF));
            default: w.amount = 16'($urandom_range(0, 20000));
          endcase
        end else begin
          pick = $urandom_range(0, 9);
          case (pick)
            0: w.amount = 16'd0;
            1: w.amount = 16'hFFFF;
            2: w.amount = 16'($urandom_range(0, 16'hFFFF));
            default: w.amount = 16'($urandom_range(1, 4000));
          endcase
        end
        send_word(w, 0, '0);
      end
    end
    steady = 1'b0;

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("fit_policy_block_allocator: match");
    else
      $display("fit_policy_block_allocator: mismatch");
    $finish;
  end

endmodule
